/* src/bbp_pkg.sv */
// ============================================================================
// bbp_pkg
// Types and constants shared by the bimodal branch predictor.
// ============================================================================
package bbp_pkg;

    // Table geometry (direct mapped, power-of-two depth)
    localparam int TABLE_ENTRIES = 1024;
    localparam int COUNT_BITS    = 32;
    localparam int ADDR_W        = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TAG_W         = ADDR_W - IDX_W;
    localparam int REPORT_W      = 32;

    // Two-bit counter states
    localparam logic [1:0] CTR_STRONG_NT = 2'd0;
    localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
    localparam logic [1:0] CTR_WEAK_T    = 2'd2;
    localparam logic [1:0] CTR_STRONG_T  = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Input word: one resolved branch
    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } in_word_t;

    // Output word: prediction report
    typedef struct packed {
        logic                predicted_taken;
        logic                correct;
        logic [1:0]          new_counter;
        logic [REPORT_W-1:0] entry_hits;
        logic [REPORT_W-1:0] entry_misses;
        logic                entry_replaced;
    } out_word_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic                  valid;
        logic [TAG_W-1:0]      tag;
        logic [1:0]            counter;
        logic [COUNT_BITS-1:0] hit_count;
        logic [COUNT_BITS-1:0] miss_count;
    } entry_t;

endpackage

/* src/bimodal_branch_predictor_unit.sv */
// ============================================================================
// bimodal_branch_predictor_unit
// Direct-mapped table of two-bit saturating counters with per-entry
// hit/miss counts; one report word per resolved branch.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  s_      | in        | s_valid / s_ready  | bbp_pkg::in_word_t  s_data
//  m_      | out       | m_valid / m_ready  | bbp_pkg::out_word_t m_data
//
//  One word per cycle sustained while the output is not stalled; a word's
//  report is offered from the output register (table read when the word is
//  accepted, then the update stage writes its result into the output register).
//  The single-port-read table memory sets the pace: read on accept,
//  read-modify-write in the update stage, with a bypass for back-to-back words
//  that hit the same entry.
//  After reset the table is swept clean, all TABLE_ENTRIES (1024) entries,
//  s_ready low throughout.
//  A stalled output holds the update stage, which in turn drops s_ready.
// ============================================================================
module bimodal_branch_predictor_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bbp_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bbp_pkg::out_word_t m_data
);
    import bbp_pkg::*;

    // Table memory
    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    // Clear sweep
    logic             clearing_reg, clearing_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;

    // Update stage
    logic             s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    logic             s1_taken_reg;
    logic             bypass_reg;
    entry_t           bypass_data_reg;

    // Output register
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg;

    logic             s_fire, s1_fire;
    logic [IDX_W-1:0] s_idx;
    logic [TAG_W-1:0] s_tag;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    entry_t           cur, upd;
    logic             replaced, predict, hit;
    out_word_t        res;

    // Handshake
    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing_reg && (!s1_valid_reg || s1_fire);
    assign s_fire  = s_valid && s_ready;
    assign s_idx   = s_data.branch_address[IDX_W-1:0];
    assign s_tag   = s_data.branch_address[ADDR_W-1:IDX_W];

    // Entry as seen by the update stage (bypass covers same-cycle write)
    always_comb begin
        cur      = bypass_reg ? bypass_data_reg : rd_data_reg;
        replaced = !cur.valid || (cur.tag != s1_tag_reg);
        if (replaced) begin
            cur.valid      = 1'b1;
            cur.tag        = s1_tag_reg;
            cur.counter    = CTR_WEAK_T;
            cur.hit_count  = '0;
            cur.miss_count = '0;
        end
        predict = (cur.counter == CTR_WEAK_T) || (cur.counter == CTR_STRONG_T);
        hit     = (predict == s1_taken_reg);
        upd     = cur;
        if (hit) begin
            if (cur.hit_count != COUNT_MAX) upd.hit_count = cur.hit_count + 1'b1;
        end else begin
            if (cur.miss_count != COUNT_MAX) upd.miss_count = cur.miss_count + 1'b1;
        end
        if (s1_taken_reg) begin
            if (cur.counter != CTR_STRONG_T) upd.counter = cur.counter + 2'd1;
        end else begin
            if (cur.counter != CTR_STRONG_NT) upd.counter = cur.counter - 2'd1;
        end
        res.predicted_taken = predict;
        res.correct         = hit;
        res.new_counter     = upd.counter;
        res.entry_hits      = REPORT_W'(upd.hit_count);
        res.entry_misses    = REPORT_W'(upd.miss_count);
        res.entry_replaced  = replaced;
    end

    // Memory write select: sweep first, then updates
    always_comb begin
        wr_en   = clearing_reg || s1_fire;
        wr_idx  = clearing_reg ? clr_idx_reg : s1_idx_reg;
        wr_data = upd;
        if (clearing_reg) begin
            wr_data = '0;
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (s_fire) begin
            rd_data_reg <= mem[s_idx];
        end
    end

    // Control next state
    always_comb begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg) begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                clearing_next = 1'b0;
            end
        end
        s1_valid_next = s_fire || (s1_valid_reg && !s1_fire);
        m_valid_next  = s1_fire || (m_valid_reg && !m_ready);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_idx_reg      <= s_idx;
            s1_tag_reg      <= s_tag;
            s1_taken_reg    <= s_data.taken;
            bypass_reg      <= s1_fire && (s1_idx_reg == s_idx);
            bypass_data_reg <= upd;
        end
        if (s1_fire) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // No word taken while the table sweep runs
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready)
        else $error("word accepted during table clear");

    // Sweep runs once per reset
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clearing_reg |=> !clearing_reg)
        else $error("table clear restarted");

    // A fresh report needs an update-stage word the cycle before
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("report without update-stage word");

    // Bypass only after an update in the accept cycle
    a_bypass_src: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (bypass_reg |-> $past(s1_fire)))
        else $error("bypass without prior update");

    // A fresh entry reports exactly one scored event
    a_replace_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.entry_replaced) |->
        ((m_data_reg.entry_hits + m_data_reg.entry_misses) == REPORT_W'(1)))
        else $error("replaced entry with bad counts");
`endif

endmodule
